// File: design/pitch_kalman_filter_1d_macros.svh
// Assertion macros shared by the pitch estimator RTL.
`ifndef PITCH_KALMAN_FILTER_1D_MACROS_SVH
`define PITCH_KALMAN_FILTER_1D_MACROS_SVH
`define PKF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pitch estimator assertion failed");
`define PKF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pitch estimator assertion failed");
`endif

// File: design/pkf_pkg.sv
// Types, constants and tables of the pitch estimator.
package pkf_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_N);

  localparam logic [31:0] ANGLE_RESET = 32'd4547;
  localparam logic [31:0] COV_RESET = 32'd655360;
  localparam logic [31:0] ONE_FX = 32'd65536;
  localparam logic [31:0] HALF_PI_FX = 32'd102944;
  localparam logic [15:0] DT_RESET = 16'd2185;
  localparam logic [15:0] Q_RESET = 16'd66;
  localparam logic [24:0] R_RESET = 25'd65536;

  localparam logic [1:0] CFG_STEP_TIME = 2'd0;
  localparam logic [1:0] CFG_PROCESS_NOISE = 2'd1;
  localparam logic [1:0] CFG_MEASURE_NOISE = 2'd2;

  typedef struct packed {
    logic [15:0] step_time;
    logic [15:0] process_noise;
    logic [24:0] measure_noise;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] gyro_rate;
    logic signed [20:0] accel_x;
    logic signed [20:0] accel_y;
    logic corr;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0: v = 32'd51472;
      5'd1: v = 32'd30385;
      5'd2: v = 32'd16055;
      5'd3: v = 32'd8150;
      5'd4: v = 32'd4091;
      5'd5: v = 32'd2047;
      5'd6: v = 32'd1024;
      5'd7: v = 32'd512;
      5'd8: v = 32'd256;
      5'd9: v = 32'd128;
      5'd10: v = 32'd64;
      5'd11: v = 32'd32;
      5'd12: v = 32'd16;
      5'd13: v = 32'd8;
      5'd14: v = 32'd4;
      5'd15: v = 32'd2;
      5'd16: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage

// File: design/pkf_front.sv
// Front end: accepts a request and decides whether it takes a correction.
module pkf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        in_time_stamp,
  input  logic signed [31:0] in_gyro_rate,
  input  logic signed [20:0] in_accel_x,
  input  logic signed [20:0] in_accel_y,
  output logic               push,
  output pkf_pkg::item_t     push_item,
  input  pkf_pkg::qstat_t    qstat
);
  import pkf_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_SCALE = 5'b00010,
    F_MOD   = 5'b00100,
    F_REM   = 5'b01000,
    F_PUSH  = 5'b10000
  } fst_t;

  // ceil(2^25 / 10); exact for every 22-bit slot count below 2^22.
  localparam logic [21:0] RECIP_10 = 22'd3355444;

  fst_t st_r, st_nxt;
  logic [30:0] t_r, t_nxt;
  item_t item_r, item_nxt;
  logic [21:0] q_r, q_nxt;
  logic [18:0] quot_r, quot_nxt;
  logic [37:0] scaled;
  logic [43:0] recip_prod;
  logic [21:0] tens;

  assign in_ready = (st_r == F_IDLE);
  assign push = (st_r == F_PUSH) && !qstat.full;
  assign push_item = item_r;
  assign scaled = {7'd0, t_r} * 38'd100;
  assign recip_prod = {22'd0, q_r} * {22'd0, RECIP_10};
  assign tens = {quot_r, 3'd0} + {2'd0, quot_r, 1'b0};

  always_comb begin
    st_nxt = st_r;
    t_nxt = t_r;
    item_nxt = item_r;
    q_nxt = q_r;
    quot_nxt = quot_r;
    unique case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          t_nxt = in_time_stamp;
          item_nxt.gyro_rate = in_gyro_rate;
          item_nxt.accel_x = in_accel_x;
          item_nxt.accel_y = in_accel_y;
          st_nxt = F_SCALE;
        end
      end
      F_SCALE: begin
        q_nxt = scaled[37:16];
        st_nxt = F_MOD;
      end
      F_MOD: begin
        quot_nxt = recip_prod[43:25];
        st_nxt = F_REM;
      end
      F_REM: begin
        item_nxt.corr = (q_r == tens);
        st_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!qstat.full) begin
          st_nxt = F_IDLE;
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    item_r <= item_nxt;
    q_r <= q_nxt;
    quot_r <= quot_nxt;
  end
endmodule

// File: design/pkf_queue.sv
// Two-entry queue between the front end and the back end.
module pkf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pkf_pkg::item_t  push_item,
  input  logic            pop,
  output pkf_pkg::item_t  pop_item,
  output pkf_pkg::qstat_t qstat
);
  import pkf_pkg::*;

  item_t mem_r [2];
  logic wr_r, rd_r;
  logic [1:0] cnt_r;

  assign pop_item = mem_r[rd_r];
  assign qstat.full = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end
endmodule

// File: design/pkf_mul.sv
// Sign-magnitude 16.16 multiplier with truncation, two register stages.
module pkf_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] res
);
  logic v1_r, v2_r;
  logic [31:0] ma_r, mb_r, prod_r;
  logic neg1_r, neg2_r;
  logic [63:0] full;

  assign full = {32'd0, ma_r} * {32'd0, mb_r};
  assign done = v2_r;
  assign res = neg2_r ? (32'd0 - prod_r) : prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= go;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ma_r <= a[31] ? (32'd0 - a) : a;
    mb_r <= b[31] ? (32'd0 - b) : b;
    neg1_r <= a[31] ^ b[31];
    prod_r <= full[47:16];
    neg2_r <= neg1_r;
  end
endmodule

// File: design/pkf_div.sv
// Bit-serial signed divider, truncating, 40-bit dividend by 32-bit divisor.
module pkf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [39:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [39:0] quo,
  output logic [31:0] rem
);
  localparam logic [5:0] DIV_LAST = 6'd39;

  logic busy_r, done_r;
  logic [5:0] cnt_r;
  logic [39:0] nm_r, qm_r;
  logic [31:0] dm_r, rm_r;
  logic sq_r, sr_r;
  logic [32:0] sh;
  logic fits;

  assign sh = {rm_r, nm_r[39]};
  assign fits = (sh >= {1'b0, dm_r});
  assign done = done_r;
  assign quo = sq_r ? (40'd0 - qm_r) : qm_r;
  assign rem = sr_r ? (32'd0 - rm_r) : rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_LAST);
      if (go) begin
        busy_r <= 1'b1;
      end else if (cnt_r == DIV_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      nm_r <= num[39] ? (40'd0 - num) : num;
      dm_r <= den[31] ? (32'd0 - den) : den;
      sq_r <= num[39] ^ den[31];
      sr_r <= num[39];
      rm_r <= 32'd0;
      qm_r <= 40'd0;
      cnt_r <= 6'd0;
    end else if (busy_r) begin
      rm_r <= fits ? 32'(sh - {1'b0, dm_r}) : sh[31:0];
      qm_r <= {qm_r[38:0], fits};
      nm_r <= {nm_r[38:0], 1'b0};
      cnt_r <= cnt_r + 6'd1;
    end
  end
endmodule

// File: design/pkf_back.sv
// Back end: prediction, CORDIC angle, gain and covariance update sequencer.
module pkf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pkf_pkg::cfg_t      cfg,
  input  pkf_pkg::qstat_t    qstat,
  output logic               pop,
  input  pkf_pkg::item_t     pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pitch_estimate,
  output logic               out_corrected,
  output logic               mul_go,
  output logic [31:0]        mul_a,
  output logic [31:0]        mul_b,
  input  logic               mul_done,
  input  logic [31:0]        mul_res,
  output logic               div_go,
  output logic [39:0]        div_num,
  output logic [31:0]        div_den,
  input  logic               div_done,
  input  logic [39:0]        div_quo,
  input  logic [31:0]        div_rem
);
  import pkf_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_CORDIC = 6'b000100,
    ST_DIVQ   = 6'b001000,
    ST_DIVF   = 6'b010000,
    ST_OUT    = 6'b100000
  } bst_t;

  localparam logic [2:0] PH_Q = 3'd0;
  localparam logic [2:0] PH_RATE = 3'd1;
  localparam logic [2:0] PH_INNOV = 3'd2;
  localparam logic [2:0] PH_OMK = 3'd3;
  localparam logic [2:0] PH_KK = 3'd4;
  localparam logic [2:0] PH_C1 = 3'd5;
  localparam logic [2:0] PH_C2 = 3'd6;

  bst_t st_r, st_nxt;
  logic [2:0] ph_r, ph_nxt;
  logic mgo_r, mgo_nxt, dgo_r, dgo_nxt;
  logic outv_r, outv_nxt;
  item_t item_r, item_nxt;
  logic [31:0] angle_r, angle_nxt, cov_r, cov_nxt;
  logic [31:0] meas_r, meas_nxt, k_r, k_nxt, m1_r, m1_nxt, m2_r, m2_nxt;
  logic [31:0] c1_r, c1_nxt, rem_r, rem_nxt;
  logic signed [23:0] x_r, x_nxt, y_r, y_nxt;
  logic [31:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic [31:0] outp_r, outp_nxt;
  logic outc_r, outc_nxt;
  logic [31:0] e_val, d_val, omk, r_ext, at;
  logic signed [23:0] x0, y0, dx, dy;

  assign r_ext = {7'd0, cfg.measure_noise};
  assign e_val = cov_r + r_ext;
  assign d_val = 32'($signed(e_val) >>> 8);
  assign omk = ONE_FX - k_r;
  assign x0 = 24'(item_r.accel_x);
  assign y0 = 24'sd0 - 24'(item_r.accel_y);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign at = atan_entry(i_r);

  assign pop = (st_r == ST_IDLE) && !qstat.empty;
  assign mul_go = mgo_r;
  assign div_go = dgo_r;
  assign out_valid = outv_r;
  assign out_pitch_estimate = outp_r;
  assign out_corrected = outc_r;

  always_comb begin
    unique case (ph_r)
      PH_Q: begin
        mul_a = {16'd0, cfg.process_noise};
        mul_b = {16'd0, cfg.step_time};
      end
      PH_RATE: begin
        mul_a = item_r.gyro_rate;
        mul_b = {16'd0, cfg.step_time};
      end
      PH_INNOV: begin
        mul_a = k_r;
        mul_b = meas_r - angle_r;
      end
      PH_OMK: begin
        mul_a = omk;
        mul_b = omk;
      end
      PH_KK: begin
        mul_a = k_r;
        mul_b = k_r;
      end
      PH_C1: begin
        mul_a = cov_r;
        mul_b = m1_r;
      end
      default: begin
        mul_a = r_ext;
        mul_b = m2_r;
      end
    endcase
  end

  always_comb begin
    if (st_r == ST_DIVF) begin
      div_num = {rem_r, 8'd0};
      div_den = d_val;
    end else begin
      div_num = {{8{cov_r[31]}}, cov_r};
      div_den = e_val;
    end
  end

  always_comb begin
    st_nxt = st_r;
    ph_nxt = ph_r;
    mgo_nxt = 1'b0;
    dgo_nxt = 1'b0;
    outv_nxt = outv_r && !out_ready;
    item_nxt = item_r;
    angle_nxt = angle_r;
    cov_nxt = cov_r;
    meas_nxt = meas_r;
    k_nxt = k_r;
    m1_nxt = m1_r;
    m2_nxt = m2_r;
    c1_nxt = c1_r;
    rem_nxt = rem_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    outp_nxt = outp_r;
    outc_nxt = outc_r;
    unique case (st_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          item_nxt = pop_item;
          ph_nxt = PH_Q;
          mgo_nxt = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          unique case (ph_r)
            PH_Q: begin
              cov_nxt = cov_r + mul_res;
              ph_nxt = PH_RATE;
              mgo_nxt = 1'b1;
            end
            PH_RATE: begin
              angle_nxt = angle_r + mul_res;
              if (item_r.corr) begin
                i_nxt = 5'd0;
                x_nxt = x0;
                y_nxt = y0;
                z_nxt = 32'd0;
                if (x0 == 24'sd0 && y0 == 24'sd0) begin
                  i_nxt = CORDIC_LAST;
                end else if (x0 < 24'sd0) begin
                  if (y0 >= 24'sd0) begin
                    x_nxt = y0;
                    y_nxt = 24'sd0 - x0;
                    z_nxt = HALF_PI_FX;
                  end else begin
                    x_nxt = 24'sd0 - y0;
                    y_nxt = x0;
                    z_nxt = 32'd0 - HALF_PI_FX;
                  end
                end
                st_nxt = ST_CORDIC;
              end else begin
                st_nxt = ST_OUT;
              end
            end
            PH_INNOV: begin
              angle_nxt = angle_r + mul_res;
              ph_nxt = PH_OMK;
              mgo_nxt = 1'b1;
            end
            PH_OMK: begin
              m1_nxt = mul_res;
              ph_nxt = PH_KK;
              mgo_nxt = 1'b1;
            end
            PH_KK: begin
              m2_nxt = mul_res;
              ph_nxt = PH_C1;
              mgo_nxt = 1'b1;
            end
            PH_C1: begin
              c1_nxt = mul_res;
              ph_nxt = PH_C2;
              mgo_nxt = 1'b1;
            end
            default: begin
              cov_nxt = c1_r + mul_res;
              st_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_CORDIC: begin
        if (i_r == CORDIC_LAST) begin
          meas_nxt = z_r;
          if (e_val == 32'd0) begin
            k_nxt = 32'd0;
            ph_nxt = PH_INNOV;
            mgo_nxt = 1'b1;
            st_nxt = ST_MUL;
          end else begin
            dgo_nxt = 1'b1;
            st_nxt = ST_DIVQ;
          end
        end else begin
          if (!y_r[23]) begin
            x_nxt = x_r + dx;
            y_nxt = y_r - dy;
            z_nxt = z_r + at;
          end else begin
            x_nxt = x_r - dx;
            y_nxt = y_r + dy;
            z_nxt = z_r - at;
          end
          i_nxt = i_r + 5'd1;
        end
      end
      ST_DIVQ: begin
        if (div_done) begin
          k_nxt = {div_quo[15:0], 16'd0};
          rem_nxt = div_rem;
          if (d_val == 32'd0) begin
            ph_nxt = PH_INNOV;
            mgo_nxt = 1'b1;
            st_nxt = ST_MUL;
          end else begin
            dgo_nxt = 1'b1;
            st_nxt = ST_DIVF;
          end
        end
      end
      ST_DIVF: begin
        if (div_done) begin
          k_nxt = k_r + div_quo[31:0];
          ph_nxt = PH_INNOV;
          mgo_nxt = 1'b1;
          st_nxt = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!outv_r || out_ready) begin
          outv_nxt = 1'b1;
          outp_nxt = angle_r;
          outc_nxt = item_r.corr;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ph_r <= PH_Q;
      mgo_r <= 1'b0;
      dgo_r <= 1'b0;
      outv_r <= 1'b0;
      angle_r <= ANGLE_RESET;
      cov_r <= COV_RESET;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
      mgo_r <= mgo_nxt;
      dgo_r <= dgo_nxt;
      outv_r <= outv_nxt;
      angle_r <= angle_nxt;
      cov_r <= cov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    meas_r <= meas_nxt;
    k_r <= k_nxt;
    m1_r <= m1_nxt;
    m2_r <= m2_nxt;
    c1_r <= c1_nxt;
    rem_r <= rem_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    outp_r <= outp_nxt;
    outc_r <= outc_nxt;
  end
endmodule

// File: design/pitch_kalman_filter_1d.sv
// Top level of the one-state pitch estimator fusing a gyro and an accelerometer.
// Each request carries a 15.16 time stamp, a gyro pitch rate and two accelerometer
// axes, and produces exactly one result: the updated pitch angle and a flag that
// tells whether a measurement correction was applied. The front end decides the
// correction in steps (accept, scale, reciprocal multiply, compare, hand-off), and
// takes no new request until it has handed off the last one. A request without
// correction then takes two passes of the multiplier in the back end. A corrected
// request also runs the CORDIC loop, one step per cycle, up to two passes of the
// bit-serial divider and seven multiplies in all. A two-entry queue and an output
// register let the front end and the back end stall independently.
// Configuration writes are always taken and must be made while the block is idle.
`include "pitch_kalman_filter_1d_macros.svh"
module pitch_kalman_filter_1d (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        in_time_stamp,
  input  logic signed [31:0] in_gyro_rate,
  input  logic signed [20:0] in_accel_x,
  input  logic signed [20:0] in_accel_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pitch_estimate,
  output logic               out_corrected,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_data
);
  import pkf_pkg::*;

  cfg_t cfg_r;
  logic q_push, q_pop;
  item_t q_in, q_out;
  qstat_t q_stat;
  logic mul_go, mul_done;
  logic [31:0] mul_a, mul_b, mul_res;
  logic div_go, div_done;
  logic [39:0] div_num, div_quo;
  logic [31:0] div_den, div_rem;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_time <= DT_RESET;
      cfg_r.process_noise <= Q_RESET;
      cfg_r.measure_noise <= R_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_STEP_TIME: cfg_r.step_time <= cfg_data[15:0];
        CFG_PROCESS_NOISE: cfg_r.process_noise <= cfg_data[15:0];
        CFG_MEASURE_NOISE: cfg_r.measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  pkf_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_time_stamp(in_time_stamp), .in_gyro_rate(in_gyro_rate),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y),
    .push(q_push), .push_item(q_in), .qstat(q_stat)
  );

  pkf_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_item(q_in),
    .pop(q_pop), .pop_item(q_out), .qstat(q_stat)
  );

  pkf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .go(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .res(mul_res)
  );

  pkf_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  pkf_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .qstat(q_stat),
    .pop(q_pop), .pop_item(q_out),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pitch_estimate(out_pitch_estimate), .out_corrected(out_corrected),
    .mul_go(mul_go), .mul_a(mul_a), .mul_b(mul_b),
    .mul_done(mul_done), .mul_res(mul_res),
    .div_go(div_go), .div_num(div_num), .div_den(div_den),
    .div_done(div_done), .div_quo(div_quo), .div_rem(div_rem)
  );

  `PKF_ASSERT_SAME(a_no_push_full, q_push, !q_stat.full)
  `PKF_ASSERT_SAME(a_no_pop_empty, q_pop, !q_stat.empty)
  `PKF_ASSERT_NEXT(a_front_busy, in_valid && in_ready, !in_ready)
endmodule

// File: tb/sv/pitch_kalman_filter_1d_checker.sv
// Checker for the pitch estimator: predicts each result and compares it with the block's output.
module pitch_kalman_filter_1d_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [30:0]        in_time_stamp,
  input  logic signed [31:0] in_gyro_rate,
  input  logic signed [20:0] in_accel_x,
  input  logic signed [20:0] in_accel_y,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pitch_estimate,
  input  logic               out_corrected,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [24:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 result_count,
  output int                 corrected_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pkf_pkg::*;

  typedef struct {
    logic [31:0] pitch;
    logic        corr;
  } pitch_result_t;

  pitch_result_t pitch_queue[$];
  logic [31:0] angle_q;
  logic [31:0] cov_q;
  logic [15:0] dt_q;
  logic [15:0] q_noise_q;
  logic [24:0] r_noise_q;

  function automatic logic [31:0] fx_product(input logic [31:0] a, input logic [31:0] b);
    logic neg;
    logic [31:0] af, ai, bf, bi, r;
    neg = a[31] ^ b[31];
    if (a[31]) a = -a;
    if (b[31]) b = -b;
    af = {16'd0, a[15:0]};
    ai = {16'd0, a[31:16]};
    bf = {16'd0, b[15:0]};
    bi = {16'd0, b[31:16]};
    r = ((af * bf) >> 16) + af * bi + ai * bf + ((ai * bi) << 16);
    return neg ? -r : r;
  endfunction

  function automatic logic [31:0] fx_quotient(input logic [31:0] au, input logic [31:0] bu);
    longint a, b, q, r, d, frac;
    a = longint'(signed'(au));
    b = longint'(signed'(bu));
    frac = 0;
    if (b == 0) return 32'd0;
    q = a / b;
    r = a % b;
    d = b >>> 8;
    if (d != 0) frac = (r * 256) / d;
    return (32'(q) << 16) + 32'(frac);
  endfunction

  function automatic longint atan_step(input int i);
    longint tab[17];
    tab = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
            256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 17) ? tab[i] : 0;
  endfunction

  function automatic logic [31:0] measured_angle(input longint y, input longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(HALF_PI_FX);
      end else begin
        x = -y;
        y = t;
        z = -longint'(HALF_PI_FX);
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += atan_step(i);
      end else begin
        x -= dx;
        y += dy;
        z -= atan_step(i);
      end
    end
    return 32'(z);
  endfunction

  function automatic void predict_pitch(input logic [30:0] ts, input logic [31:0] rate,
                                        input logic signed [20:0] ax,
                                        input logic signed [20:0] ay);
    pitch_result_t res;
    logic [31:0] meas, e, k, omk;
    longint unsigned slot;
    slot = (64'(ts) * 100) / 65536;
    res.corr = 1'b0;
    cov_q += fx_product({16'd0, q_noise_q}, {16'd0, dt_q});
    angle_q += fx_product(rate, {16'd0, dt_q});
    if (slot % 10 == 0) begin
      meas = measured_angle(-longint'(ay), longint'(ax));
      e = cov_q + {7'd0, r_noise_q};
      k = fx_quotient(cov_q, e);
      omk = ONE_FX - k;
      angle_q += fx_product(k, meas - angle_q);
      cov_q = fx_product(cov_q, fx_product(omk, omk))
            + fx_product({7'd0, r_noise_q}, fx_product(k, k));
      res.corr = 1'b1;
    end
    res.pitch = angle_q;
    pitch_queue.push_back(res);
  endfunction

  always @(posedge clk) begin
    pitch_result_t exp_r;
    if (!rst_n) begin
      angle_q = ANGLE_RESET;
      cov_q = COV_RESET;
      dt_q = DT_RESET;
      q_noise_q = Q_RESET;
      r_noise_q = R_RESET;
      pitch_queue.delete();
      fail_count <= 0;
      pending <= 0;
      result_count <= 0;
      corrected_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (out_corrected) corrected_count <= corrected_count + 1;
        if (pitch_queue.size() == 0) begin
          $display("%0t: unexpected result pitch=%0d corrected=%0b",
                   $time, out_pitch_estimate, out_corrected);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = pitch_queue.pop_front();
          if (out_pitch_estimate !== exp_r.pitch || out_corrected !== exp_r.corr) begin
            $display("%0t: mismatch expected pitch=%0d corrected=%0b actual pitch=%0d corrected=%0b",
                     $time, signed'(exp_r.pitch), exp_r.corr, out_pitch_estimate, out_corrected);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        predict_pitch(in_time_stamp, in_gyro_rate, in_accel_x, in_accel_y);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_TIME: dt_q = cfg_data[15:0];
          CFG_PROCESS_NOISE: q_noise_q = cfg_data[15:0];
          CFG_MEASURE_NOISE: r_noise_q = cfg_data;
          default: ;
        endcase
      end
      pending <= pitch_queue.size();
    end
  end

  final begin
    if (pitch_queue.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, pitch_queue.size());
  end
endmodule

// File: tb/sv/pitch_kalman_filter_1d_tb.sv
// Top of the pitch estimator testbench: clock, reset, stimulus and verdict.
module pitch_kalman_filter_1d_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pkf_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [30:0]        in_time_stamp;
  logic signed [31:0] in_gyro_rate;
  logic signed [20:0] in_accel_x;
  logic signed [20:0] in_accel_y;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pitch_estimate;
  logic               out_corrected;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [24:0]        cfg_data;
  int                 fail_count;
  int                 pending;
  int                 result_count;
  int                 corrected_count;
  bit                 quiet;
  bit                 hold_req;

  pitch_kalman_filter_1d u_dut (.*);

  pitch_kalman_filter_1d_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_time_stamp = '0;
    in_gyro_rate = '0;
    in_accel_x = '0;
    in_accel_y = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEP_TIME;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
  end

  always #2 clk = ~clk;

  initial begin
    #10ms;
    $display("pitch_kalman_filter_1d_tb failed");
    $finish;
  end

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_request(input logic [30:0] ts, input logic [31:0] rate,
                              input logic [20:0] ax, input logic [20:0] ay);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_time_stamp <= ts;
    in_gyro_rate <= rate;
    in_accel_x <= ax;
    in_accel_y <= ay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [24:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] dt, input logic [15:0] qn,
                            input logic [24:0] rn);
    write_reg(CFG_STEP_TIME, {9'd0, dt});
    write_reg(CFG_PROCESS_NOISE, {9'd0, qn});
    write_reg(CFG_MEASURE_NOISE, rn);
  endtask

  task automatic send_random();
    logic [30:0] ts;
    logic [31:0] rate;
    longint unsigned slot;
    ts = 31'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      slot = (64'(ts) * 100) >> 16;
      slot -= slot % 10;
      ts = 31'((slot * 65536 + 99) / 100);
    end
    if ($urandom_range(0, 3) == 0) rate = $urandom;
    else rate = 32'($signed($urandom_range(0, 524288)) - 262144);
    send_request(ts, rate, 21'($urandom), 21'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_filter(DT_RESET, Q_RESET, R_RESET);

    send_request(31'd0, 32'd0, 21'd0, 21'd0);
    send_request(31'h7fffffff, 32'h7fffffff, 21'h0fffff, 21'h0fffff);
    send_request(31'd0, 32'h80000000, 21'h100000, 21'h100000);
    send_request(31'd655, 32'hffffffff, 21'h100000, 21'd0);
    send_request(31'd656, 32'd65536, -21'sd65536, 21'd65536);
    send_request(31'd6554, 32'd1, -21'sd65536, -21'sd65536);
    send_request(31'd0, 32'd0, 21'd0, 21'd65536);
    send_request(31'd0, 32'd0, 21'd0, -21'sd65536);
    send_request(31'd0, 32'd0, 21'd65536, 21'd0);
    send_request(31'd0, 32'd0, -21'sd1, 21'd0);
    send_request(31'd1000, 32'h7fffffff, 21'h0fffff, 21'h100000);
    send_request(31'd65536, 32'h80000000, 21'h100000, 21'h0fffff);
    send_request(31'h7ffffff0, 32'd0, 21'd1, 21'd1);
    send_request(31'd0, 32'hfffe0000, 21'd0, 21'd0);
    wait_idle();

    set_filter(16'hffff, 16'hffff, 25'd16777216);
    for (int i = 0; i < 330; i++) begin
      if (i == 50) hold_req = 1'b1;
      send_random();
    end
    wait_idle();

    set_filter(16'd0, 16'd0, 25'd256);
    for (int i = 0; i < 330; i++) send_random();
    wait_idle();

    set_filter(16'($urandom), 16'($urandom), 25'($urandom_range(256, 16777216)));
    for (int i = 0; i < 330; i++) send_random();
    wait_idle();

    set_filter(DT_RESET, Q_RESET, R_RESET);
    write_reg(CFG_UNUSED, 25'h1ffffff);
    for (int i = 0; i < 330; i++) send_random();
    wait_idle();

    set_filter(16'($urandom), 16'($urandom_range(0, 255)),
               25'($urandom_range(256, 1048576)));
    quiet = 1'b1;
    for (int i = 0; i < 330; i++) send_random();
    wait_idle();

    $display("Checked %0d results, %0d of them with a measurement correction,",
             result_count, corrected_count);
    $display("over six filter settings including the register extremes.");
    if (fail_count == 0 && pending == 0) begin
      $display("pitch_kalman_filter_1d_tb passed");
    end else begin
      $display("pitch_kalman_filter_1d_tb failed");
    end
    $finish;
  end
endmodule
